### design/full_circle_angle_defines.svh
// Assertion macros shared by the full_circle_angle RTL.
// Expects signals named clk and rst in the module that uses them.
`ifndef FULL_CIRCLE_ANGLE_DEFINES_SVH
`define FULL_CIRCLE_ANGLE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FCA_ASSERT_HOLDS(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("full_circle_angle: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define FCA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("full_circle_angle: next-cycle check failed");

`endif

### design/fca_pkg.sv
// Package for full_circle_angle: widths, angle constants, arctangent table,
// and the side-band struct that travels with each item. No dependencies.
`timescale 1ns / 1ps

package fca_pkg;

  localparam int COORD_W        = 32;  // Q16.16 coordinates
  localparam int DIFF_W         = 33;  // coordinate differences
  localparam int NORM_W         = 40;  // normalized magnitudes, MSB at bit 39
  localparam int CORDIC_W       = 44;  // signed CORDIC x/y datapath
  localparam int Z_W            = 27;  // signed Q.24 angle accumulator
  localparam int Q_W            = 17;  // rounded first-quadrant angle, Q.16
  localparam int ANGLE_W        = 19;  // unsigned Q3.16 output
  localparam int FOLD_W         = 20;  // headroom for quadrant folding
  localparam int MAX_ITER       = 24;
  localparam int ITERATIONS_DEF = 16;

  localparam logic [Z_W-2:0]   HALF_PI_Q24       = 26'd26353589;
  localparam logic [ANGLE_W-1:0] ZERO_Q16        = 19'd0;
  localparam logic [ANGLE_W-1:0] HALF_PI_Q16     = 19'd102944;
  localparam logic [ANGLE_W-1:0] PI_Q16          = 19'd205887;
  localparam logic [ANGLE_W-1:0] THREE_HALF_PI_Q16 = 19'd308831;
  localparam logic [FOLD_W-1:0]  TWO_PI_Q16      = 20'd411775;

  // atan(2^-i) * 2^24, rounded to nearest
  localparam logic [23:0] ATAN_Q24 [MAX_ITER] = '{
    24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331, 24'd1047214, 24'd524117,
    24'd262123,   24'd131069,  24'd65536,   24'd32768,   24'd16384,   24'd8192,
    24'd4096,     24'd2048,    24'd1024,    24'd512,     24'd256,     24'd128,
    24'd64,       24'd32,      24'd16,      24'd8,       24'd4,       24'd2
  };

  // Quadrant and special-case info carried alongside the datapath
  typedef struct packed {
    logic               special;     // on an axis or coincident
    logic               x_neg;
    logic               y_neg;
    logic [ANGLE_W-1:0] fixed_angle; // answer when special
  } fca_side_t;

endpackage

### design/fca_front.sv
// Front end: 33-bit differences, then magnitudes and axis classification.
// Two register stages. Depends on fca_pkg.
`timescale 1ns / 1ps

module fca_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [fca_pkg::COORD_W-1:0] origin_x,
  input  logic signed [fca_pkg::COORD_W-1:0] origin_y,
  input  logic signed [fca_pkg::COORD_W-1:0] target_x,
  input  logic signed [fca_pkg::COORD_W-1:0] target_y,
  output logic                              out_valid,
  output logic [fca_pkg::NORM_W-1:0]        mag_x,
  output logic [fca_pkg::NORM_W-1:0]        mag_y,
  output fca_pkg::fca_side_t                side
);
  import fca_pkg::*;

  logic                     diff_valid;
  logic signed [DIFF_W-1:0] diff_x;
  logic signed [DIFF_W-1:0] diff_y;

  logic [DIFF_W-1:0] abs_x;
  logic [DIFF_W-1:0] abs_y;
  fca_side_t         side_next;

  // stage 1: differences, sign-extended so they never overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      diff_valid <= 1'b0;
    end else if (en) begin
      diff_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      diff_x <= {target_x[COORD_W-1], target_x} - {origin_x[COORD_W-1], origin_x};
      diff_y <= {target_y[COORD_W-1], target_y} - {origin_y[COORD_W-1], origin_y};
    end
  end

  // stage 2: magnitudes and classification
  always_comb begin
    side_next.x_neg = diff_x[DIFF_W-1];
    side_next.y_neg = diff_y[DIFF_W-1];
    abs_x = side_next.x_neg ? (~diff_x + 1'b1) : diff_x;
    abs_y = side_next.y_neg ? (~diff_y + 1'b1) : diff_y;
    side_next.special     = (diff_x == '0) || (diff_y == '0);
    side_next.fixed_angle = ZERO_Q16;
    if (diff_x == '0 && diff_y == '0) begin
      side_next.fixed_angle = ZERO_Q16;
    end else if (diff_x == '0) begin
      side_next.fixed_angle = side_next.y_neg ? THREE_HALF_PI_Q16 : HALF_PI_Q16;
    end else if (diff_y == '0) begin
      side_next.fixed_angle = side_next.x_neg ? PI_Q16 : ZERO_Q16;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= diff_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_x <= {{(NORM_W-DIFF_W){1'b0}}, abs_x};
      mag_y <= {{(NORM_W-DIFF_W){1'b0}}, abs_y};
      side  <= side_next;
    end
  end

endmodule

### design/fca_norm_stage.sv
// One normalization stage: two conditional left shifts of the magnitude pair,
// driven by the leading bits of their OR. Depends on fca_pkg.
`timescale 1ns / 1ps

module fca_norm_stage #(
  parameter int SH_A = 2,
  parameter int SH_B = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [fca_pkg::NORM_W-1:0] in_x,
  input  logic [fca_pkg::NORM_W-1:0] in_y,
  input  fca_pkg::fca_side_t         in_side,
  output logic                       out_valid,
  output logic [fca_pkg::NORM_W-1:0] out_x,
  output logic [fca_pkg::NORM_W-1:0] out_y,
  output fca_pkg::fca_side_t         out_side
);
  import fca_pkg::*;

  logic [NORM_W-1:0] mid_x, mid_y, fin_x, fin_y;
  logic              shift_a, shift_b;

  // shift when the top SH bits of the pair are all clear
  always_comb begin
    shift_a = ((in_x | in_y) >> (NORM_W - SH_A)) == '0;
    mid_x   = shift_a ? (in_x << SH_A) : in_x;
    mid_y   = shift_a ? (in_y << SH_A) : in_y;
    shift_b = ((mid_x | mid_y) >> (NORM_W - SH_B)) == '0;
    fin_x   = shift_b ? (mid_x << SH_B) : mid_x;
    fin_y   = shift_b ? (mid_y << SH_B) : mid_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x    <= fin_x;
      out_y    <= fin_y;
      out_side <= in_side;
    end
  end

endmodule

### design/fca_cordic_stage.sv
// One CORDIC vectoring micro-rotation, registered.
// Rotation index set by IDX. Depends on fca_pkg (widths, arctangent table).
`timescale 1ns / 1ps

module fca_cordic_stage #(
  parameter int IDX = 0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  logic signed [fca_pkg::CORDIC_W-1:0] in_x,
  input  logic signed [fca_pkg::CORDIC_W-1:0] in_y,
  input  logic signed [fca_pkg::Z_W-1:0]      in_z,
  input  fca_pkg::fca_side_t                  in_side,
  output logic                                out_valid,
  output logic signed [fca_pkg::CORDIC_W-1:0] out_x,
  output logic signed [fca_pkg::CORDIC_W-1:0] out_y,
  output logic signed [fca_pkg::Z_W-1:0]      out_z,
  output fca_pkg::fca_side_t                  out_side
);
  import fca_pkg::*;

  localparam logic signed [Z_W-1:0] ANG = Z_W'(ATAN_Q24[IDX]);

  logic signed [CORDIC_W-1:0] xs, ys, x_next, y_next;
  logic signed [Z_W-1:0]      z_next;

  always_comb begin
    xs = in_x >>> IDX;
    ys = in_y >>> IDX;
    if (in_y[CORDIC_W-1]) begin
      x_next = in_x - ys;
      y_next = in_y + xs;
      z_next = in_z - ANG;
    end else begin
      x_next = in_x + ys;
      y_next = in_y - xs;
      z_next = in_z + ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_x    <= x_next;
      out_y    <= y_next;
      out_z    <= z_next;
      out_side <= in_side;
    end
  end

endmodule

### design/fca_back.sv
// Back end: clamp and round the CORDIC angle, fold into its quadrant,
// then an output register with a skid entry. Depends on fca_pkg and defines.
`timescale 1ns / 1ps
`include "full_circle_angle_defines.svh"

module fca_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic signed [fca_pkg::Z_W-1:0] in_z,
  input  fca_pkg::fca_side_t             in_side,
  output logic                           ready_up,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fca_pkg::ANGLE_W-1:0]    angle_rad
);
  import fca_pkg::*;

  logic               en;
  logic [Z_W-2:0]     z_clamp;
  logic [Z_W-2:0]     z_round;
  logic               rnd_valid;
  logic [Q_W-1:0]     rnd_q;
  fca_side_t          rnd_side;
  logic [FOLD_W-1:0]  folded;
  logic [FOLD_W-1:0]  wrapped;
  logic [ANGLE_W-1:0] fold_angle;
  logic               push;
  logic               skid_valid;
  logic [ANGLE_W-1:0] skid_angle;

  assign en       = !skid_valid;
  assign ready_up = en;

  // clamp to [0, pi/2] and round Q.24 -> Q.16
  always_comb begin
    if (in_z[Z_W-1]) begin
      z_clamp = '0;
    end else if (in_z[Z_W-2:0] > HALF_PI_Q24) begin
      z_clamp = HALF_PI_Q24;
    end else begin
      z_clamp = in_z[Z_W-2:0];
    end
    z_round = z_clamp + (Z_W-1)'(128);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd_valid <= 1'b0;
    end else if (en) begin
      rnd_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rnd_q    <= z_round[Q_W+7:8];
      rnd_side <= in_side;
    end
  end

  // quadrant fold, wrap at two pi
  always_comb begin
    case ({rnd_side.x_neg, rnd_side.y_neg})
      2'b00:   folded = {{(FOLD_W-Q_W){1'b0}}, rnd_q};
      2'b10:   folded = {1'b0, PI_Q16} - {{(FOLD_W-Q_W){1'b0}}, rnd_q};
      2'b11:   folded = {1'b0, PI_Q16} + {{(FOLD_W-Q_W){1'b0}}, rnd_q};
      default: folded = TWO_PI_Q16 - {{(FOLD_W-Q_W){1'b0}}, rnd_q};
    endcase
    wrapped    = (folded >= TWO_PI_Q16) ? (folded - TWO_PI_Q16) : folded;
    fold_angle = rnd_side.special ? rnd_side.fixed_angle : wrapped[ANGLE_W-1:0];
  end

  assign push = rnd_valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      if (skid_valid) begin
        angle_rad <= skid_angle;
      end else if (push) begin
        angle_rad <= fold_angle;
      end
    end else if (push) begin
      skid_angle <= fold_angle;
    end
  end

  `FCA_ASSERT_HOLDS(a_skid_behind_out, skid_valid, out_valid)
  `FCA_ASSERT_HOLDS(a_angle_below_two_pi, out_valid, angle_rad < TWO_PI_Q16[ANGLE_W-1:0])
  `FCA_ASSERT_NEXT(a_stall_fills_skid, push && out_valid && !out_ready, skid_valid)
  `FCA_ASSERT_NEXT(a_drain_empties, out_valid && out_ready && !skid_valid && !push, !out_valid)

endmodule

### design/full_circle_angle.sv
// Top level of full_circle_angle: direction from origin to target point.
// Uses fca_pkg, fca_front, fca_norm_stage, fca_cordic_stage, fca_back.
//
//   channel | signals                                   | dir
//   --------+-------------------------------------------+----
//   in      | in_valid, in_ready, origin_x/y, target_x/y | in
//   out     | out_valid, out_ready, angle_rad           | out
//
// One item per cycle sustained while the skid entry is empty. A result passes,
// after its item is accepted, through 2 front stages (difference, magnitude),
// 3 normalize stages, one stage per CORDIC micro-rotation, one clamp/round
// stage, then the output register. Reset clears every valid bit; data
// registers are not reset. A stalled output parks one result in a skid entry;
// while that entry is full the whole pipeline holds and in_ready is low.
`timescale 1ns / 1ps

module full_circle_angle #(
  parameter int ITERATIONS = fca_pkg::ITERATIONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [fca_pkg::COORD_W-1:0] origin_x,
  input  logic signed [fca_pkg::COORD_W-1:0] origin_y,
  input  logic signed [fca_pkg::COORD_W-1:0] target_x,
  input  logic signed [fca_pkg::COORD_W-1:0] target_y,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fca_pkg::ANGLE_W-1:0]       angle_rad
);
  import fca_pkg::*;

  localparam int NSTG = 3;  // normalize stages, two shifts each
  localparam int SH_A [NSTG] = '{32, 8, 2};
  localparam int SH_B [NSTG] = '{16, 4, 1};

  // global advance: the pipeline moves whenever the skid entry is free
  logic en;

  logic              nv [NSTG+1];
  logic [NORM_W-1:0] nx [NSTG+1];
  logic [NORM_W-1:0] ny [NSTG+1];
  fca_side_t         ns [NSTG+1];

  logic                       cv [ITERATIONS+1];
  logic signed [CORDIC_W-1:0] cx [ITERATIONS+1];
  logic signed [CORDIC_W-1:0] cy [ITERATIONS+1];
  logic signed [Z_W-1:0]      cz [ITERATIONS+1];
  fca_side_t                  cs [ITERATIONS+1];

  assign in_ready = en;

  fca_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .origin_x  (origin_x),
    .origin_y  (origin_y),
    .target_x  (target_x),
    .target_y  (target_y),
    .out_valid (nv[0]),
    .mag_x     (nx[0]),
    .mag_y     (ny[0]),
    .side      (ns[0])
  );

  // leading-zero normalization: larger magnitude ends with bit 39 set
  for (genvar n = 0; n < NSTG; n++) begin : g_norm
    fca_norm_stage #(
      .SH_A (SH_A[n]),
      .SH_B (SH_B[n])
    ) u_norm (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (nv[n]),
      .in_x      (nx[n]),
      .in_y      (ny[n]),
      .in_side   (ns[n]),
      .out_valid (nv[n+1]),
      .out_x     (nx[n+1]),
      .out_y     (ny[n+1]),
      .out_side  (ns[n+1])
    );
  end

  // CORDIC entry: non-negative magnitudes, z starts at zero
  assign cv[0] = nv[NSTG];
  assign cx[0] = {{(CORDIC_W-NORM_W){1'b0}}, nx[NSTG]};
  assign cy[0] = {{(CORDIC_W-NORM_W){1'b0}}, ny[NSTG]};
  assign cz[0] = '0;
  assign cs[0] = ns[NSTG];

  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cordic
    fca_cordic_stage #(
      .IDX (i)
    ) u_rot (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (cv[i]),
      .in_x      (cx[i]),
      .in_y      (cy[i]),
      .in_z      (cz[i]),
      .in_side   (cs[i]),
      .out_valid (cv[i+1]),
      .out_x     (cx[i+1]),
      .out_y     (cy[i+1]),
      .out_z     (cz[i+1]),
      .out_side  (cs[i+1])
    );
  end

  // final x/y magnitudes are not needed; only the angle is used
  fca_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cv[ITERATIONS]),
    .in_z      (cz[ITERATIONS]),
    .in_side   (cs[ITERATIONS]),
    .ready_up  (en),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .angle_rad (angle_rad)
  );

endmodule

### bench/tb.sv
// Self-checking bench for full_circle_angle: a clocked driver and monitor with
// an angle predictor, random and directed point pairs, varied backpressure.
// Depends on fca_pkg (coordinate and angle widths) and the full_circle_angle RTL.
`timescale 1ns / 1ps

module tb;

  import fca_pkg::*;

  localparam int CORDIC_STEPS = 16;
  localparam int LATENCY      = CORDIC_STEPS + 6;
  localparam int IDLE_LIMIT   = 3000;   // cycles with no item moving on either side
  localparam int HOLD_CYCLES  = 300;    // long receiver hold-off

  // Angle constants, Q3.16 radians (first-quadrant clamp in Q.24)
  localparam longint QUARTER_Q24   = 64'd26353589;
  localparam int     QUARTER_TURN  = 102944;
  localparam int     HALF_TURN     = 205887;
  localparam int     THREE_QUARTER = 308831;
  localparam int     FULL_TURN     = 411775;
  localparam longint NORM_FLOOR    = 64'd1 << 39;

  // atan(2^-i) in Q.24
  localparam longint ARCTAN_STEP [0:23] = '{
    13176795, 7778716, 4110060, 2086331, 1047214, 524117,
    262123, 131069, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128,
    64, 32, 16, 8, 4, 2
  };

  localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic signed [COORD_W-1:0] ox;
    logic signed [COORD_W-1:0] oy;
    logic signed [COORD_W-1:0] tx;
    logic signed [COORD_W-1:0] ty;
  } point_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_W-1:0] origin_x = '0;
  logic signed [COORD_W-1:0] origin_y = '0;
  logic signed [COORD_W-1:0] target_x = '0;
  logic signed [COORD_W-1:0] target_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ANGLE_W-1:0] angle_rad;

  point_pair_t        pending_points[$];
  logic [ANGLE_W-1:0] expected_angles[$];

  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  int  hold_req       = 0;     // bumped by the sequencer to ask for a hold-off
  int  hold_seen      = 0;
  int  hold_left      = 0;
  int  mismatches     = 0;
  int  quiet_cycles   = 0;
  logic in_accepted   = 1'b0;  // item taken at the last rising edge

  full_circle_angle #(.ITERATIONS(CORDIC_STEPS)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .origin_x  (origin_x),
    .origin_y  (origin_y),
    .target_x  (target_x),
    .target_y  (target_y),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .angle_rad (angle_rad)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Direction of target relative to origin, Q3.16 in [0, 2*pi).
  function automatic logic [ANGLE_W-1:0] predict_angle(input point_pair_t p);
    longint dx, dy, x, y, z, xs, ys;
    int     q, a;
    dx = longint'($signed(p.tx)) - longint'($signed(p.ox));
    dy = longint'($signed(p.ty)) - longint'($signed(p.oy));
    if (dx == 0 && dy == 0) begin
      a = 0;
    end else if (dx == 0) begin
      a = (dy > 0) ? QUARTER_TURN : THREE_QUARTER;
    end else if (dy == 0) begin
      a = (dx > 0) ? 0 : HALF_TURN;
    end else begin
      x = (dx < 0) ? -dx : dx;
      y = (dy < 0) ? -dy : dy;
      // scale both up until the larger one has its MSB at bit 39
      while (x < NORM_FLOOR && y < NORM_FLOOR) begin
        x = x * 2;
        y = y * 2;
      end
      z = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y < 0) begin
          x = x - ys;
          y = y + xs;
          z = z - ARCTAN_STEP[i];
        end else begin
          x = x + ys;
          y = y - xs;
          z = z + ARCTAN_STEP[i];
        end
      end
      if (z < 0) z = 0;
      if (z > QUARTER_Q24) z = QUARTER_Q24;
      q = int'((z + 128) >>> 8);
      // fold into the quadrant of (dx, dy)
      if (dx > 0 && dy > 0)      a = q;
      else if (dx < 0 && dy > 0) a = HALF_TURN - q;
      else if (dx < 0)           a = HALF_TURN + q;
      else                       a = FULL_TURN - q;
      if (a >= FULL_TURN) a = a - FULL_TURN;
    end
    return a[ANGLE_W-1:0];
  endfunction

  task automatic add_pair(input logic signed [COORD_W-1:0] ox, oy, tx, ty);
    point_pair_t p;
    p.ox = ox;
    p.oy = oy;
    p.tx = tx;
    p.ty = ty;
    pending_points.push_back(p);
  endtask

  function automatic logic signed [COORD_W-1:0] pick_corner();
    case ($urandom_range(0, 4))
      0: return C_MIN;
      1: return C_MAX;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  // Random point pair; mix of full-range, small offsets, axes, coincident, corners, near-axis.
  function automatic point_pair_t random_pair();
    point_pair_t p;
    int kind;
    kind = $urandom_range(0, 99);
    p.ox = $urandom;
    p.oy = $urandom;
    p.tx = $urandom;
    p.ty = $urandom;
    if (kind < 30) begin
      // keep full random
    end else if (kind < 60) begin
      p.tx = p.ox + $signed($urandom_range(0, 8192)) - 4096;
      p.ty = p.oy + $signed($urandom_range(0, 8192)) - 4096;
    end else if (kind < 68) begin
      p.ty = p.oy;                       // horizontal
    end else if (kind < 76) begin
      p.tx = p.ox;                       // vertical
    end else if (kind < 81) begin
      p.tx = p.ox;                       // coincident
      p.ty = p.oy;
    end else if (kind < 90) begin
      p.ox = pick_corner();
      p.oy = pick_corner();
      p.tx = pick_corner();
      p.ty = pick_corner();
    end else if (kind < 95) begin
      // just off the horizontal axis
      p.ty = p.oy + $signed($urandom_range(0, 6)) - 3;
    end else begin
      // just off the vertical axis
      p.tx = p.ox + $signed($urandom_range(0, 6)) - 3;
    end
    return p;
  endfunction

  // Sender: new payload only at falling edges, hold while not yet taken.
  always @(negedge clk) begin
    point_pair_t p;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_accepted) begin
      // waiting for in_ready, payload held
    end else if (pending_points.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
      p = pending_points.pop_front();
      origin_x <= p.ox;
      origin_y <= p.oy;
      target_x <= p.tx;
      target_y <= p.ty;
      in_valid <= 1'b1;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: record each accepted item's angle, check each result in order.
  always @(posedge clk) begin
    point_pair_t p;
    logic [ANGLE_W-1:0] want;
    if (rst) begin
      in_accepted <= 1'b0;
    end else begin
      in_accepted <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        p.ox = origin_x;
        p.oy = origin_y;
        p.tx = target_x;
        p.ty = target_y;
        expected_angles.push_back(predict_angle(p));
      end
      if (out_valid && out_ready) begin
        if (expected_angles.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with nothing expected, angle_rad=%0d", $realtime,
                     angle_rad);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_angles.pop_front();
          if (angle_rad !== want) begin
            if (mismatches < 10)
              $display("%0t: angle_rad mismatch: expected %0d, got %0d", $realtime,
                       want, angle_rad);
            mismatches <= mismatches + 1;
          end
        end
      end
    end
  end

  // Watchdog: no item moving on either channel for too long ends the run.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("timeout: nothing accepted for %0d cycles", IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Wait until every queued item went in and every result came out.
  task automatic drain();
    while (pending_points.size() != 0 || in_valid) @(posedge clk);
    while (expected_angles.size() != 0) @(posedge clk);
  endtask

  task automatic random_phase(input int n, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) pending_points.push_back(random_pair());
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: coincident, the four axes, extreme differences, corners,
    // tiny vectors in each quadrant, near-axis angles incl. wrap at two pi.
    add_pair(0, 0, 0, 0);
    add_pair(C_MIN, C_MAX, C_MIN, C_MAX);
    add_pair(0, 0, 1, 0);
    add_pair(0, 0, -1, 0);
    add_pair(0, 0, 0, 1);
    add_pair(0, 0, 0, -1);
    add_pair(C_MIN, 7, C_MAX, 7);
    add_pair(C_MAX, -7, C_MIN, -7);
    add_pair(5, C_MIN, 5, C_MAX);
    add_pair(-5, C_MAX, -5, C_MIN);
    add_pair(C_MIN, C_MIN, C_MAX, C_MAX);
    add_pair(C_MAX, C_MAX, C_MIN, C_MIN);
    add_pair(C_MAX, C_MIN, C_MIN, C_MAX);
    add_pair(C_MIN, C_MAX, C_MAX, C_MIN);
    add_pair(0, 0, 1, 1);
    add_pair(0, 0, -1, 1);
    add_pair(0, 0, -1, -1);
    add_pair(0, 0, 1, -1);
    add_pair(C_MIN, 0, C_MAX, -1);
    add_pair(C_MIN, 0, C_MAX, 1);
    add_pair(0, C_MIN, 1, C_MAX);
    add_pair(0, C_MIN, -1, C_MAX);
    add_pair(C_MAX, 0, C_MIN, -1);
    add_pair(0, C_MAX, 1, C_MIN);
    drain();

    random_phase(200, 0, 0);
    random_phase(200, 61, 0);
    random_phase(200, 0, 61);
    random_phase(200, 15, 15);

    // Fill the pipeline against a long receiver hold-off so in_ready drops.
    hold_req = hold_req + 1;
    random_phase(60, 0, 0);

    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && expected_angles.size() == 0) begin
      $display("CHECK OK");
    end else begin
      if (expected_angles.size() != 0)
        $display("%0d results never arrived", expected_angles.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
